>>> src/rin_pkg.sv
// Package: types, constants and symbol tables of the integer to Roman numeral converter.
package rin_pkg;

   localparam int VALUE_W  = 12;
   localparam int SYMBOL_W = 7;
   localparam int DIGIT_W  = 4;
   localparam int WEIGHT_W = 14;

   localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd3999;

   // ASCII codes of the numeral symbols
   localparam logic [SYMBOL_W-1:0] SYM_NONE = 7'h00;
   localparam logic [SYMBOL_W-1:0] SYM_I    = 7'h49;
   localparam logic [SYMBOL_W-1:0] SYM_V    = 7'h56;
   localparam logic [SYMBOL_W-1:0] SYM_X    = 7'h58;
   localparam logic [SYMBOL_W-1:0] SYM_L    = 7'h4C;
   localparam logic [SYMBOL_W-1:0] SYM_C    = 7'h43;
   localparam logic [SYMBOL_W-1:0] SYM_D    = 7'h44;
   localparam logic [SYMBOL_W-1:0] SYM_M    = 7'h4D;

   // Decade index: 0 units, 1 tens, 2 hundreds, 3 thousands
   typedef logic [1:0] decade_type;
   localparam decade_type DEC_UNITS     = 2'd0;
   localparam decade_type DEC_TENS      = 2'd1;
   localparam decade_type DEC_HUNDREDS  = 2'd2;
   localparam decade_type DEC_THOUSANDS = 2'd3;

   typedef logic [DIGIT_W-1:0] digit_type;

   typedef struct packed {
      logic                  out_of_range;
      logic [3:0][DIGIT_W-1:0] digits;
   } entry_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_DIGIT,
      FRONT_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      KIND_ONE,
      KIND_FIVE,
      KIND_TEN
   } symbol_kind_type;

   // d times the power of ten of a decade
   function automatic logic [WEIGHT_W-1:0] weight(decade_type dec, digit_type d);
      logic [WEIGHT_W-1:0] pow;
      unique case (dec)
         DEC_THOUSANDS: pow = 14'd1000;
         DEC_HUNDREDS:  pow = 14'd100;
         DEC_TENS:      pow = 14'd10;
         default:       pow = 14'd1;
      endcase
      return WEIGHT_W'(pow * WEIGHT_W'(d));
   endfunction

   // number of symbols a digit spells
   function automatic logic [2:0] digit_len(digit_type d);
      logic [2:0] len;
      unique case (d)
         4'd0:                      len = 3'd0;
         4'd1, 4'd5:                len = 3'd1;
         4'd2, 4'd4, 4'd6, 4'd9:    len = 3'd2;
         4'd3, 4'd7:                len = 3'd3;
         4'd8:                      len = 3'd4;
         default:                   len = 3'd0;
      endcase
      return len;
   endfunction

   // which symbol of the decade stands at position p of a digit
   function automatic symbol_kind_type digit_kind(digit_type d, logic [1:0] p);
      symbol_kind_type kind;
      if (d == 4'd9) begin
         kind = (p == 2'd0) ? KIND_ONE : KIND_TEN;
      end else if (d == 4'd4) begin
         kind = (p == 2'd0) ? KIND_ONE : KIND_FIVE;
      end else if (d >= 4'd5) begin
         kind = (p == 2'd0) ? KIND_FIVE : KIND_ONE;
      end else begin
         kind = KIND_ONE;
      end
      return kind;
   endfunction

   function automatic logic [SYMBOL_W-1:0] symbol_of(decade_type dec, symbol_kind_type kind);
      logic [SYMBOL_W-1:0] s;
      unique case (dec)
         DEC_UNITS:
            unique case (kind)
               KIND_ONE:  s = SYM_I;
               KIND_FIVE: s = SYM_V;
               default:   s = SYM_X;
            endcase
         DEC_TENS:
            unique case (kind)
               KIND_ONE:  s = SYM_X;
               KIND_FIVE: s = SYM_L;
               default:   s = SYM_C;
            endcase
         DEC_HUNDREDS:
            unique case (kind)
               KIND_ONE:  s = SYM_C;
               KIND_FIVE: s = SYM_D;
               default:   s = SYM_M;
            endcase
         default:       s = SYM_M;
      endcase
      return s;
   endfunction

endpackage

>>> src/rin_req_if.sv
// Interface: input channel carrying the integer to convert.
interface rin_req_if;
   logic                             valid;
   logic                             ready;
   logic [rin_pkg::VALUE_W-1:0]      value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

>>> src/rin_rsp_if.sv
// Interface: result channel carrying one numeral symbol per item.
interface rin_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [rin_pkg::SYMBOL_W-1:0]     symbol;
   logic                             last;
   logic                             out_of_range;

   modport source (output valid, output symbol, output last, output out_of_range, input ready);
   modport sink   (input valid, input symbol, input last, input out_of_range, output ready);
endinterface

>>> src/integer_to_roman_numeral.sv
// Top level: integer to Roman numeral converter.
//
// req_chan takes one 12-bit value per item. rsp_chan returns the numeral as
// one ASCII symbol per item (I V X L C D M), most significant first, with
// last set on the final symbol. A value of 0 or above 3999 returns a single
// item with symbol 0, last 1 and out_of_range 1.
//
// The front end takes a value in an accept step; an in-range value then
// gets one compare-and-subtract digit step each for thousands, hundreds
// and tens (the units are the remainder), then a push step that waits
// while the queue is full; an out-of-range value goes from accept to push.
// The back end loads an entry from the queue, then sends one symbol per
// cycle while rsp_chan is not stalled, stepping over zero decades without
// a symbol, and loads the next entry once the last symbol is sent. The
// slower of the two ends sets the sustained rate.
//
// A stalled rsp_chan holds its symbol in the output register while the back
// end waits; the queue of QUEUE_DEPTH entries lets the front end keep taking
// values meanwhile. Reset empties the queue and the output register; there is
// no clearing pass and nothing is kept between items.
module integer_to_roman_numeral #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   rin_req_if.sink    req_chan,
   rin_rsp_if.source  rsp_chan
);

   logic               push_valid;
   rin_pkg::entry_type push_data;
   logic               q_full;
   logic               q_pop;
   rin_pkg::entry_type q_data;
   logic               q_empty;

   rin_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_full  (q_full)
   );

   rin_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   rin_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_data  (q_data),
      .q_pop   (q_pop),
      .rsp     (rsp_chan)
   );

`ifndef SYNTHESIS
   // error items carry no symbol and close the numeral
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.out_of_range) |->
         (rsp_chan.last && (rsp_chan.symbol == rin_pkg::SYM_NONE)))
      else $error("out_of_range item without last or with a symbol");

   // valid numeral items always carry a real symbol
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.out_of_range) |->
         (rsp_chan.symbol != rin_pkg::SYM_NONE))
      else $error("numeral item with empty symbol");

   // no result item right after reset
   assert property (@(posedge clock) (!reset && $past(reset)) |-> !rsp_chan.valid)
      else $error("result item valid right after reset");
`endif

endmodule

>>> src/rin_front.sv
// Front end: accepts a value, checks its range and splits it into decimal digits.
module rin_front (
   input  logic                 clock,
   input  logic                 reset,
   rin_req_if.sink              req,
   output logic                 push_valid,
   output rin_pkg::entry_type   push_data,
   input  logic                 push_full
);

   rin_pkg::front_state_type state_ff, state_in;
   logic [rin_pkg::VALUE_W-1:0]  rem_ff, rem_in;
   rin_pkg::decade_type          stage_ff, stage_in;
   rin_pkg::entry_type           entry_ff, entry_in;

   rin_pkg::digit_type           dig;
   logic [rin_pkg::WEIGHT_W-1:0] dig_weight;
   logic [rin_pkg::VALUE_W-1:0]  rem_next;
   logic                         accept;
   logic                         bad_value;

   assign accept    = req.valid && req.ready;
   assign bad_value = (req.value == '0) || (req.value > rin_pkg::VALUE_MAX);

   // largest digit whose weight fits into the remainder
   always_comb begin
      dig = '0;
      for (int d = 1; d < 10; d++) begin
         if ({2'b00, rem_ff} >= rin_pkg::weight(stage_ff, rin_pkg::DIGIT_W'(d))) begin
            dig = rin_pkg::DIGIT_W'(d);
         end
      end
      dig_weight = rin_pkg::weight(stage_ff, dig);
      rem_next   = rin_pkg::VALUE_W'({2'b00, rem_ff} - dig_weight);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rin_pkg::FRONT_IDLE: begin
            if (accept) begin
               state_in = bad_value ? rin_pkg::FRONT_PUSH : rin_pkg::FRONT_DIGIT;
            end
         end
         rin_pkg::FRONT_DIGIT: begin
            if (stage_ff == rin_pkg::DEC_TENS) begin
               state_in = rin_pkg::FRONT_PUSH;
            end
         end
         rin_pkg::FRONT_PUSH: begin
            if (!push_full) begin
               state_in = rin_pkg::FRONT_IDLE;
            end
         end
         default: state_in = rin_pkg::FRONT_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req.ready  = (state_ff == rin_pkg::FRONT_IDLE);
      push_valid = (state_ff == rin_pkg::FRONT_PUSH);
      push_data  = entry_ff;
   end

   // digit extraction datapath
   always_comb begin
      rem_in   = rem_ff;
      stage_in = stage_ff;
      entry_in = entry_ff;
      if (accept) begin
         rem_in                = req.value;
         stage_in              = rin_pkg::DEC_THOUSANDS;
         entry_in.out_of_range = bad_value;
         entry_in.digits       = '0;
      end else if (state_ff == rin_pkg::FRONT_DIGIT) begin
         rem_in                    = rem_next;
         stage_in                  = stage_ff - 2'd1;
         entry_in.digits[stage_ff] = dig;
         if (stage_ff == rin_pkg::DEC_TENS) begin
            entry_in.digits[rin_pkg::DEC_UNITS] = rem_next[rin_pkg::DIGIT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rin_pkg::FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
      rem_ff   <= rem_in;
      stage_ff <= stage_in;
      entry_ff <= entry_in;
   end

endmodule

>>> src/rin_queue.sv
// Queue: short register FIFO of digit entries between front and back.
module rin_queue #(
   parameter int DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rin_pkg::entry_type   push_data,
   output logic                 full,
   input  logic                 pop,
   output rin_pkg::entry_type   pop_data,
   output logic                 empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rin_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> src/rin_back.sv
// Back end: walks the digits of one entry and sends one symbol per cycle while the output is not stalled.
module rin_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  rin_pkg::entry_type   q_data,
   output logic                 q_pop,
   rin_rsp_if.source            rsp
);

   rin_pkg::entry_type           entry_ff, entry_in;
   logic                         have_ff, have_in;
   rin_pkg::decade_type          dec_ff, dec_in;
   logic [1:0]                   pos_ff, pos_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [rin_pkg::SYMBOL_W-1:0] rsp_symbol_ff, rsp_symbol_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic                         rsp_oor_ff, rsp_oor_in;

   rin_pkg::digit_type           cur_digit;
   logic [2:0]                   cur_len;
   logic                         lower_zero;
   logic                         digit_end;
   logic                         is_last;
   logic                         slot_free;
   logic                         emit;
   logic [rin_pkg::SYMBOL_W-1:0] cur_symbol;

   // current digit and its symbol
   always_comb begin
      cur_digit  = entry_ff.digits[dec_ff];
      cur_len    = rin_pkg::digit_len(cur_digit);
      cur_symbol = rin_pkg::symbol_of(dec_ff, rin_pkg::digit_kind(cur_digit, pos_ff));
      lower_zero = 1'b1;
      for (int j = 0; j < 3; j++) begin
         if ((rin_pkg::decade_type'(j) < dec_ff) && (entry_ff.digits[j] != '0)) begin
            lower_zero = 1'b0;
         end
      end
      digit_end = ({1'b0, pos_ff} + 3'd1 == cur_len);
      is_last   = entry_ff.out_of_range || (digit_end && lower_zero);
   end

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign emit      = have_ff && slot_free && (entry_ff.out_of_range || (cur_len != '0));
   assign q_pop     = !have_ff && !q_empty;

   // sequencer over decades and symbol positions
   always_comb begin
      entry_in = entry_ff;
      have_in  = have_ff;
      dec_in   = dec_ff;
      pos_in   = pos_ff;
      if (q_pop) begin
         entry_in = q_data;
         have_in  = 1'b1;
         dec_in   = rin_pkg::DEC_THOUSANDS;
         pos_in   = '0;
      end else if (have_ff) begin
         if (!entry_ff.out_of_range && (cur_len == '0)) begin
            // digit spells nothing: step to the next decade
            dec_in = dec_ff - 2'd1;
         end else if (emit) begin
            if (digit_end) begin
               pos_in = '0;
               dec_in = dec_ff - 2'd1;
            end else begin
               pos_in = pos_ff + 2'd1;
            end
            if (is_last) begin
               have_in = 1'b0;
            end
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_oor_in    = rsp_oor_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_symbol_in = entry_ff.out_of_range ? rin_pkg::SYM_NONE : cur_symbol;
         rsp_last_in   = is_last;
         rsp_oor_in    = entry_ff.out_of_range;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      entry_ff      <= entry_in;
      dec_ff        <= dec_in;
      pos_ff        <= pos_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_oor_ff    <= rsp_oor_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.symbol       = rsp_symbol_ff;
   assign rsp.last         = rsp_last_ff;
   assign rsp.out_of_range = rsp_oor_ff;

endmodule

>>> test/tb_top.sv
// Testbench for integer_to_roman_numeral: random and directed values checked against a numeral speller.
module tb_top;

   localparam int ITEM_COUNT  = 126;
   localparam int QUIET_LIMIT = 2000;
   localparam int LONG_HOLD   = 300;
   localparam int SETTLE      = 40;

   typedef struct {
      logic [rin_pkg::SYMBOL_W-1:0] symbol;
      logic                         last;
      logic                         out_of_range;
   } symbol_rec_type;

   typedef struct {
      logic [rin_pkg::VALUE_W-1:0] value;
      int                          gap;
      bit                          drain;
   } value_job_type;

   logic clock;
   logic reset;

   rin_req_if req_bus();
   rin_rsp_if rsp_bus();

   integer_to_roman_numeral dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   value_job_type  pending_values[$];
   symbol_rec_type expected_symbols[$];
   int             error_count  = 0;
   int             symbols_seen = 0;
   int             quiet_cycles = 0;
   bit             value_taken  = 1'b0;

   // clock
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // one/five/ten symbols of a decade (0 units .. 3 thousands)
   function automatic void decade_symbols(input int decade,
                                          output logic [rin_pkg::SYMBOL_W-1:0] one,
                                          output logic [rin_pkg::SYMBOL_W-1:0] five,
                                          output logic [rin_pkg::SYMBOL_W-1:0] ten);
      case (decade)
         0: begin
            one = rin_pkg::SYM_I; five = rin_pkg::SYM_V; ten = rin_pkg::SYM_X;
         end
         1: begin
            one = rin_pkg::SYM_X; five = rin_pkg::SYM_L; ten = rin_pkg::SYM_C;
         end
         2: begin
            one = rin_pkg::SYM_C; five = rin_pkg::SYM_D; ten = rin_pkg::SYM_M;
         end
         default: begin
            one = rin_pkg::SYM_M; five = rin_pkg::SYM_M; ten = rin_pkg::SYM_M;
         end
      endcase
   endfunction

   function automatic void push_symbol(input logic [rin_pkg::SYMBOL_W-1:0] s);
      symbol_rec_type rec;
      rec.symbol       = s;
      rec.last         = 1'b0;
      rec.out_of_range = 1'b0;
      expected_symbols.push_back(rec);
   endfunction

   // expected symbols for one value, appended to expected_symbols
   function automatic void spell_numeral(input logic [rin_pkg::VALUE_W-1:0] value);
      int                           v;
      int                           d;
      int                           decade;
      int                           scale;
      logic [rin_pkg::SYMBOL_W-1:0] one, five, ten;
      symbol_rec_type               rec;
      v = int'(value);
      if (v == 0 || value > rin_pkg::VALUE_MAX) begin
         rec.symbol       = rin_pkg::SYM_NONE;
         rec.last         = 1'b1;
         rec.out_of_range = 1'b1;
         expected_symbols.push_back(rec);
      end else begin
         scale = 1000;
         for (decade = 3; decade >= 0; decade--) begin
            d = (v / scale) % 10;
            decade_symbols(decade, one, five, ten);
            if (d == 9) begin
               push_symbol(one);
               push_symbol(ten);
            end else if (d == 4) begin
               push_symbol(one);
               push_symbol(five);
            end else begin
               if (d >= 5) begin
                  push_symbol(five);
                  d = d - 5;
               end
               repeat (d) push_symbol(one);
            end
            scale = scale / 10;
         end
         // value >= 1, so at least one symbol was pushed
         rec = expected_symbols.pop_back();
         rec.last = 1'b1;
         expected_symbols.push_back(rec);
      end
   endfunction

   task automatic check_field(input string name, input logic [rin_pkg::SYMBOL_W-1:0] want,
                              input logic [rin_pkg::SYMBOL_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endtask

   // monitor: predict on accepted values, check accepted symbols
   always @(posedge clock) begin
      symbol_rec_type want;
      bit             sym_taken;
      if (reset) begin
         value_taken  = 1'b0;
         quiet_cycles = 0;
      end else begin
         value_taken = req_bus.valid && req_bus.ready;
         sym_taken   = rsp_bus.valid && rsp_bus.ready;
         if (value_taken) spell_numeral(req_bus.value);
         if (sym_taken) begin
            symbols_seen++;
            if (expected_symbols.size() == 0) begin
               $error("unexpected item: symbol %0h last %0b out_of_range %0b",
                      rsp_bus.symbol, rsp_bus.last, rsp_bus.out_of_range);
               error_count++;
            end else begin
               want = expected_symbols.pop_front();
               check_field("symbol", want.symbol, rsp_bus.symbol);
               check_field("last", rin_pkg::SYMBOL_W'(want.last),
                           rin_pkg::SYMBOL_W'(rsp_bus.last));
               check_field("out_of_range", rin_pkg::SYMBOL_W'(want.out_of_range),
                           rin_pkg::SYMBOL_W'(rsp_bus.out_of_range));
            end
         end
         quiet_cycles = (value_taken || sym_taken) ? 0 : quiet_cycles + 1;
      end
   end

   // driver: offers queued values, honoring gaps and drain points
   always @(negedge clock) begin
      value_job_type job;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && !value_taken) begin
         // hold the offered item until accepted
      end else if (pending_values.size() == 0) begin
         req_bus.valid <= 1'b0;
      end else if (pending_values[0].drain && expected_symbols.size() != 0) begin
         req_bus.valid <= 1'b0;
      end else if (pending_values[0].gap > 0) begin
         req_bus.valid <= 1'b0;
         pending_values[0].gap = pending_values[0].gap - 1;
      end else begin
         job = pending_values.pop_front();
         req_bus.valid <= 1'b1;
         req_bus.value <= job.value;
      end
   end

   // receiver: random stalls, calm stretches, and one long hold-off
   int hold_left = 0;
   int rx_phase  = 0;
   bit rx_calm   = 1'b0;
   bit held_once = 1'b0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (!held_once && symbols_seen >= 40) begin
            held_once = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (rx_phase == 0) begin
            rx_calm  = ($urandom_range(0, 2) == 0);
            rx_phase = 100;
         end else begin
            rx_phase--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (rx_calm) begin
            rsp_bus.ready <= 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                    : $urandom_range(0, 2);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // watchdog
   initial begin
      @(negedge reset);
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("** integer_to_roman_numeral: FAILED **");
      $finish;
   end

   function automatic void add_value(input logic [rin_pkg::VALUE_W-1:0] value, input int gap,
                                     input bit drain);
      value_job_type job;
      job.value = value;
      job.gap   = gap;
      job.drain = drain;
      pending_values.push_back(job);
   endfunction

   // stimulus and end of run
   initial begin
      int                          pick;
      int                          gap;
      bit                          burst;
      logic [rin_pkg::VALUE_W-1:0] value;
      int                          long_digit[3];
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;
      long_digit    = '{3, 7, 8};

      // directed: range edges, longest numeral, subtractive and additive digits
      add_value(12'd0, 0, 1'b0);
      add_value(12'd4095, 0, 1'b0);
      add_value(12'd4000, 1, 1'b0);
      add_value(12'd3999, 0, 1'b0);
      add_value(12'd1, 0, 1'b0);
      add_value(12'd3888, 0, 1'b0);
      add_value(12'd4, 2, 1'b0);
      add_value(12'd9, 0, 1'b0);
      add_value(12'd5, 0, 1'b0);
      add_value(12'd8, 0, 1'b0);
      add_value(12'd3, 0, 1'b0);
      add_value(12'd40, 3, 1'b0);
      add_value(12'd90, 0, 1'b0);
      add_value(12'd50, 0, 1'b0);
      add_value(12'd400, 0, 1'b0);
      add_value(12'd900, 0, 1'b0);
      add_value(12'd500, 0, 1'b0);
      add_value(12'd1000, 0, 1'b0);
      add_value(12'd3000, 0, 1'b0);
      add_value(12'd1994, 0, 1'b0);
      add_value(12'd444, 0, 1'b0);
      add_value(12'd999, 0, 1'b0);
      add_value(12'd2468, 0, 1'b0);
      add_value(12'd2048, 0, 1'b0);

      // random: mostly in range, some long numerals, some out of range
      burst = 1'b0;
      for (int n = 0; n < ITEM_COUNT; n++) begin
         if (n % 25 == 0) burst = ($urandom_range(0, 2) == 0);
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            value = '0;
         end else if (pick < 3) begin
            value = rin_pkg::VALUE_W'($urandom_range(4000, 4095));
         end else if (pick < 6) begin
            value = rin_pkg::VALUE_W'($urandom_range(1, 3) * 1000
                                      + long_digit[$urandom_range(0, 2)] * 100
                                      + long_digit[$urandom_range(0, 2)] * 10
                                      + long_digit[$urandom_range(0, 2)]);
         end else begin
            value = rin_pkg::VALUE_W'($urandom_range(1, 3999));
         end
         pick = $urandom_range(0, 99);
         if (burst || pick < 40)  gap = 0;
         else if (pick < 75)      gap = $urandom_range(1, 2);
         else if (pick < 95)      gap = $urandom_range(3, 8);
         else                     gap = $urandom_range(20, 50);
         add_value(value, gap, n == ITEM_COUNT / 2);
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_values.size() != 0 || req_bus.valid) @(posedge clock);
      while (expected_symbols.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (error_count == 0) begin
         $display("** integer_to_roman_numeral: PASSED **");
      end else begin
         $display("** integer_to_roman_numeral: FAILED **");
      end
      $finish;
   end

endmodule
